>>> rtl/pwaa_pkg.sv
// Shared types, codes and constants of the weighted-average projection accumulator.
package pwaa_pkg;

  localparam int unsigned SIDE_PIXELS_DEF = 256;
  localparam int unsigned MAX_DEPTH       = 65536;
  localparam logic [63:0] ONE_Q16         = 64'd65536;

  localparam logic [2:0] MODE_COLUMN = 3'd0;
  localparam logic [2:0] MODE_GAS    = 3'd1;
  localparam logic [2:0] MODE_DUST   = 3'd2;
  localparam logic [2:0] MODE_TEMP   = 3'd3;
  localparam logic [2:0] MODE_VEL    = 3'd4;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_DIR_X = 3'd1;
  localparam logic [2:0] REG_DIR_Y = 3'd2;
  localparam logic [2:0] REG_DIR_Z = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic               command;
    logic [15:0]        pixel_index;
    logic [31:0]        path_length;
    logic [31:0]        cell_size;
    logic [31:0]        gas_density;
    logic [31:0]        dust_amount;
    logic [31:0]        gas_temperature;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_pixel;
    logic signed [31:0] pixel_value;
    logic               empty_pixel;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_DOT,
    ST_MUL,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

>>> rtl/pwaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwaa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pixel_weighted_average_accumulator_unit.sv
// Weighted-average projection map: per-pixel sum and weight stores, shared multiplier sequencer.
// Accumulate multiplies: column density one, mass-weighted modes four, line-of-sight velocity
//   a dot product and two, off-map pixel or unused mode none. Read: divide, scale; empty: none.
// One transaction at a time; all work runs through one 32x32 multiplier (four partial
//   products per 64-bit multiply) and a one-bit-per-cycle divider used only on reads.
// Reset (rst, synchronous) restores the registers and then clears both stores, one entry per
//   cycle, all SIDE_PIXELS^2 entries (capped at 65536), before in_ready rises.
module pixel_weighted_average_accumulator_unit
  import pwaa_pkg::*;
#(
  parameter int unsigned SIDE_PIXELS = SIDE_PIXELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  // Store depth follows the map, but a 16-bit index never reaches past 65536 entries.
  localparam int unsigned CELLS = SIDE_PIXELS * SIDE_PIXELS;
  localparam int unsigned DEPTH = (CELLS > MAX_DEPTH) ? MAX_DEPTH : CELLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers
  logic [2:0]         mode;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [31:0]        output_scale;

  state_t state, state_next;

  in_item_t           item;
  logic [5:0]         cnt;
  logic [1:0]         step;
  logic [63:0]        op_a, op_b;
  logic [127:0]       acc;
  logic [63:0]        prod;
  logic [1:0]         pshift;
  logic               psign;
  logic signed [49:0] dot;
  logic [63:0]        wgt;
  logic [63:0]        contrib;
  logic signed [63:0] sum_r;
  logic [63:0]        wsum_r;
  logic [63:0]        rem_r, lo_r;
  logic               rd_neg;
  logic               rd_empty;
  logic [AW-1:0]      clr_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [63:0]        ram_wsum, ram_wwgt;
  logic [63:0]        rd_sum, rd_wgt;

  // Store ports
  pwaa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wsum),
    .raddr (item.pixel_index[AW-1:0]),
    .rdata (rd_sum)
  );

  pwaa_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wwgt),
    .raddr (item.pixel_index[AW-1:0]),
    .rdata (rd_wgt)
  );

  // Item decode
  logic in_map;
  assign in_map = (32'(item.pixel_index) < 32'(DEPTH)) && (32'(item.pixel_index) < CELLS);

  logic [63:0] dx64, rho64, rho_sel, prop_sel;
  assign dx64     = {32'b0, item.cell_size};
  assign rho64    = {32'b0, item.gas_density};
  assign rho_sel  = (mode == MODE_DUST) ? {32'b0, item.dust_amount} : rho64;
  always_comb begin
    unique case (mode)
      MODE_DUST: prop_sel = {32'b0, item.dust_amount};
      MODE_TEMP: prop_sel = {32'b0, item.gas_temperature};
      default:   prop_sel = rho64;
    endcase
  end

  // Shared multiplier: dot-product terms in ST_DOT, partial products otherwise
  logic [15:0] dir_k, dir_mag;
  logic [31:0] vel_k, vel_mag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        term_sign;

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    begin dir_k = dir_x; vel_k = item.vel_x; end
      2'd1:    begin dir_k = dir_y; vel_k = item.vel_y; end
      default: begin dir_k = dir_z; vel_k = item.vel_z; end
    endcase
  end

  assign dir_mag   = dir_k[15] ? 16'(-dir_k) : dir_k;
  assign vel_mag   = vel_k[31] ? 32'(-vel_k) : vel_k;
  assign term_sign = dir_k[15] ^ vel_k[31];

  assign mul_a = (state == ST_DOT) ? {16'b0, dir_mag} : op_a[32*cnt[1] +: 32];
  assign mul_b = (state == ST_DOT) ? vel_mag : op_b[32*cnt[0] +: 32];
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  logic [127:0] acc_add;
  always_comb begin
    case (pshift)
      2'd0:    acc_add = {64'b0, prod};
      2'd1:    acc_add = {32'b0, prod, 32'b0};
      2'd2:    acc_add = {prod, 64'b0};
      default: acc_add = '0;
    endcase
  end

  // Truncate by 16 and saturate to 64 bits
  logic [63:0] mul_res;
  assign mul_res = (acc[127:80] != '0) ? '1 : acc[79:16];

  logic mul_last, chain_end;
  assign mul_last  = (cnt == 6'd5);
  assign chain_end = (item.command == CMD_READ) || (mode == MODE_COLUMN) ||
                     ((mode == MODE_VEL) && (step == 2'd1)) || (step == 2'd3);

  logic [63:0] next_a, next_b;
  logic        dot_neg;
  logic [49:0] dot_abs;
  logic [63:0] vlos;
  assign dot_neg = dot[49];
  assign dot_abs = dot_neg ? 50'(-dot) : dot;
  assign vlos    = 64'(dot_abs >> 14);

  always_comb begin
    if (mode == MODE_VEL) begin
      next_a = vlos;
      next_b = mul_res;
    end else begin
      next_a = (step == 2'd2) ? prop_sel : mul_res;
      unique case (step)
        2'd0:    next_b = dx64;
        2'd1:    next_b = rho_sel;
        default: next_b = mul_res;
      endcase
    end
  end

  // Divider step: one quotient bit per cycle
  logic        div_top, div_ge;
  logic [63:0] rem_sh, rem_new;
  assign div_top = rem_r[63];
  assign rem_sh  = {rem_r[62:0], lo_r[63]};
  assign div_ge  = div_top || (rem_sh >= wsum_r);
  assign rem_new = div_ge ? rem_sh - wsum_r : rem_sh;

  // Read decode on store data
  logic [63:0] rd_mag;
  logic        rd_is_empty, rd_sat;
  assign rd_mag      = rd_sum[63] ? 64'(-rd_sum) : rd_sum;
  assign rd_is_empty = !in_map || (rd_wgt == '0);
  assign rd_sat      = {48'b0, rd_mag[63:48]} >= rd_wgt;

  // Saturating store updates
  logic [63:0]        cmag;
  logic               cneg;
  logic signed [65:0] sum_ext;
  logic [63:0]        sum_new;
  logic [64:0]        wgt_ext;
  logic [63:0]        wgt_new;
  assign cmag = contrib[63] ? 64'h7FFF_FFFF_FFFF_FFFF : contrib;
  assign cneg = (mode == MODE_VEL) && dot_neg && (vlos != '0);
  always_comb begin
    if (cneg) begin
      sum_ext = 66'(sum_r) - $signed({2'b0, cmag});
    end else begin
      sum_ext = 66'(sum_r) + $signed({2'b0, cmag});
    end
    if (sum_ext > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sum_new = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (sum_ext < -66'sh0_8000_0000_0000_0000) begin
      sum_new = 64'h8000_0000_0000_0000;
    end else begin
      sum_new = sum_ext[63:0];
    end
    wgt_ext = {1'b0, wsum_r} + {1'b0, wgt};
    if (mode == MODE_COLUMN) begin
      wgt_new = ONE_Q16;
    end else begin
      wgt_new = wgt_ext[64] ? '1 : wgt_ext[63:0];
    end
  end

  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : item.pixel_index[AW-1:0];
  assign ram_wsum  = (state == ST_CLEAR) ? '0 : sum_new;
  assign ram_wwgt  = (state == ST_CLEAR) ? '0 : wgt_new;

  // Final value saturation
  logic [31:0] final_val;
  always_comb begin
    if (rd_empty) begin
      final_val = '0;
    end else if (!rd_neg) begin
      final_val = (contrib > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : contrib[31:0];
    end else begin
      final_val = (contrib >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-contrib[31:0]);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_COLUMN;
      dir_x        <= 16'sd16384;
      dir_y        <= '0;
      dir_z        <= '0;
      output_scale <= 32'd65536;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODE:  mode         <= cfg_data[2:0];
        REG_DIR_X: dir_x        <= cfg_data[15:0];
        REG_DIR_Y: dir_y        <= cfg_data[15:0];
        REG_DIR_Z: dir_z        <= cfg_data[15:0];
        REG_SCALE: output_scale <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD: begin
        if (item.command == CMD_READ) begin
          if (rd_is_empty) begin
            state_next = ST_OUT;
          end else if (rd_sat) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_DIV;
          end
        end else if (!in_map || mode > MODE_VEL) begin
          state_next = ST_IDLE;
        end else if (mode == MODE_VEL) begin
          state_next = ST_DOT;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_DOT: begin
        if (cnt == 6'd3) begin
          state_next = ST_MUL;
        end
      end
      ST_DIV: begin
        if (cnt == 6'd63) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last && chain_end) begin
          state_next = (item.command == CMD_READ) ? ST_OUT : ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          item <= in_item;
        end
      end
      ST_LOAD: begin
        sum_r    <= rd_sum;
        wsum_r   <= rd_wgt;
        rd_neg   <= rd_sum[63];
        rd_empty <= rd_is_empty;
        cnt      <= '0;
        step     <= '0;
        acc      <= '0;
        dot      <= '0;
        rem_r    <= {48'b0, rd_mag[63:48]};
        lo_r     <= {rd_mag[47:0], 16'b0};
        if (item.command == CMD_READ) begin
          op_a <= rd_sat ? '1 : '0;
          op_b <= {32'b0, output_scale};
        end else begin
          op_a <= (mode == MODE_COLUMN || mode == MODE_VEL) ? {32'b0, item.path_length} : dx64;
          op_b <= (mode == MODE_COLUMN || mode == MODE_VEL) ? rho64 : dx64;
        end
      end
      ST_DOT: begin
        cnt <= cnt + 6'd1;
        if (cnt != 6'd3) begin
          prod  <= mul_p;
          psign <= term_sign;
        end
        if (cnt != 6'd0) begin
          dot <= psign ? dot - $signed(prod[49:0]) : dot + $signed(prod[49:0]);
        end
        if (cnt == 6'd3) begin
          cnt <= '0;
          acc <= '0;
        end
      end
      ST_DIV: begin
        cnt   <= cnt + 6'd1;
        rem_r <= rem_new;
        lo_r  <= {lo_r[62:0], 1'b0};
        op_a  <= {op_a[62:0], div_ge};
        if (cnt == 6'd63) begin
          cnt <= '0;
          acc <= '0;
        end
      end
      ST_MUL: begin
        cnt <= cnt + 6'd1;
        if (cnt < 6'd4) begin
          prod   <= mul_p;
          pshift <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != 6'd0 && !mul_last) begin
          acc <= acc + acc_add;
        end
        if (mul_last) begin
          cnt  <= '0;
          acc  <= '0;
          step <= step + 2'd1;
          if (chain_end) begin
            contrib <= mul_res;
          end else begin
            op_a <= next_a;
            op_b <= next_b;
            if (mode == MODE_VEL || step == 2'd2) begin
              wgt <= mul_res;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_item.out_pixel   <= item.pixel_index;
      out_item.pixel_value <= final_val;
      out_item.empty_pixel <= rd_empty;
    end
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while sequencer busy");

  a_store_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_WRITE))
    else $error("store written outside clear or update");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.empty_pixel |-> out_item.pixel_value == 32'sd0)
    else $error("empty pixel with nonzero value");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input taken before store clear");

endmodule

>>> dv/pixel_weighted_average_accumulator_unit_test.sv
// Self-checking testbench of the weighted-average projection map accumulator.
module pixel_weighted_average_accumulator_unit_test;
  import pwaa_pkg::*;

  localparam int unsigned MAP_CELLS  = SIDE_PIXELS_DEF * SIDE_PIXELS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
  localparam int unsigned DRAIN_CYCLES = 100;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  logic      cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pixel_weighted_average_accumulator_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and pixel stores.
  logic [2:0]         map_mode;
  logic signed [15:0] los_x, los_y, los_z;
  logic [31:0]        value_scale;
  longint             shadow_sum [int unsigned];
  longint unsigned    shadow_weight [int unsigned];

  out_item_t       pending_reads [$];
  int unsigned     error_count;
  longint unsigned cycle_count;
  bit              send_gaps;
  bit              recv_gaps;
  bit              pixel_written [int unsigned];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort the run when it takes far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Q16.16 product of two unsigned values, saturated to 64 bits.
  function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    prod = prod >> 16;
    if (prod[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return prod[63:0];
  endfunction

  // Q16.16 quotient, saturated to 64 bits.
  function automatic longint unsigned q16_div(longint unsigned n, longint unsigned d);
    logic [127:0] quo;
    quo = {64'd0, n} << 16;
    quo = quo / 128'(d);
    if (quo[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return quo[63:0];
  endfunction

  function automatic longint unsigned cell_mass(longint unsigned dx, longint unsigned rho);
    return q16_mul(q16_mul(q16_mul(dx, dx), dx), rho);
  endfunction

  // Fold one signed contribution into a pixel sum, saturating both ways.
  function automatic void add_to_sum(int unsigned pix, bit neg, longint unsigned mag);
    longint s, m;
    s = shadow_sum.exists(pix) ? shadow_sum[pix] : 0;
    m = (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'(mag);
    if (!neg)
      s = (s > 64'sh7FFF_FFFF_FFFF_FFFF - m) ? 64'sh7FFF_FFFF_FFFF_FFFF : s + m;
    else
      s = (s < -64'sh7FFF_FFFF_FFFF_FFFF - 1 + m) ? (-64'sh7FFF_FFFF_FFFF_FFFF - 1) : s - m;
    shadow_sum[pix] = s;
  endfunction

  function automatic void add_to_weight(int unsigned pix, longint unsigned w);
    longint unsigned s;
    s = shadow_weight.exists(pix) ? shadow_weight[pix] : 0;
    shadow_weight[pix] = (s > ~w) ? 64'hFFFF_FFFF_FFFF_FFFF : s + w;
  endfunction

  // Apply one transaction to the shadow map; queue the read result it yields.
  function automatic void project_item(in_item_t it);
    int unsigned     pix;
    longint unsigned mass, w, mag, quo, v;
    longint          dot;
    logic [31:0]     r;
    bit              neg;
    pix = 32'(it.pixel_index);
    if (it.command == CMD_ACCUM) begin
      if (pix >= MAP_CELLS) return;
      case (map_mode)
        MODE_COLUMN: begin
          add_to_sum(pix, 1'b0, q16_mul(it.path_length, it.gas_density));
          shadow_weight[pix] = ONE_Q16;
        end
        MODE_GAS: begin
          mass = cell_mass(it.cell_size, it.gas_density);
          add_to_sum(pix, 1'b0, q16_mul(it.gas_density, mass));
          add_to_weight(pix, mass);
        end
        MODE_DUST: begin
          mass = cell_mass(it.cell_size, it.dust_amount);
          add_to_sum(pix, 1'b0, q16_mul(it.dust_amount, mass));
          add_to_weight(pix, mass);
        end
        MODE_TEMP: begin
          mass = cell_mass(it.cell_size, it.gas_density);
          add_to_sum(pix, 1'b0, q16_mul(it.gas_temperature, mass));
          add_to_weight(pix, mass);
        end
        MODE_VEL: begin
          dot = longint'(los_x) * longint'(it.vel_x) + longint'(los_y) * longint'(it.vel_y)
              + longint'(los_z) * longint'(it.vel_z);
          neg = dot < 0;
          mag = neg ? longint'(-dot) : dot;
          mag = mag >> 14;
          w = q16_mul(it.path_length, it.gas_density);
          add_to_sum(pix, neg && mag != 0, q16_mul(mag, w));
          add_to_weight(pix, w);
        end
        default: ;
      endcase
      if (map_mode <= MODE_VEL) pixel_written[pix] = 1'b1;
      return;
    end
    if (pix >= MAP_CELLS || !shadow_weight.exists(pix) || shadow_weight[pix] == 0) begin
      pending_reads.push_back('{out_pixel: it.pixel_index, pixel_value: 0, empty_pixel: 1'b1});
      return;
    end
    neg = shadow_sum[pix] < 0;
    mag = neg ? (64'd0 - longint'(shadow_sum[pix])) : shadow_sum[pix];
    quo = q16_div(mag, shadow_weight[pix]);
    v = q16_mul(quo, value_scale);
    if (!neg) r = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
    else      r = (v >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - v[31:0]);
    pending_reads.push_back('{out_pixel: it.pixel_index, pixel_value: r, empty_pixel: 1'b0});
  endfunction

  // Check each result transaction against the oldest pending read.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result: actual %p", $time, out_item);
        error_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_item.out_pixel !== want.out_pixel) begin
          $display("%0t: out_pixel expected %0d actual %0d", $time,
                   want.out_pixel, out_item.out_pixel);
          error_count++;
        end
        if (out_item.pixel_value !== want.pixel_value) begin
          $display("%0t: pixel_value of pixel %0d expected %0h actual %0h", $time,
                   want.out_pixel, want.pixel_value, out_item.pixel_value);
          error_count++;
        end
        if (out_item.empty_pixel !== want.empty_pixel) begin
          $display("%0t: empty_pixel of pixel %0d expected %0b actual %0b", $time,
                   want.out_pixel, want.empty_pixel, out_item.empty_pixel);
          error_count++;
        end
      end
    end
  end

  // Stall the result side in random bursts while enabled.
  initial begin
    int unsigned n;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (recv_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  // Send one transaction, holding it until accepted; idle before it at random.
  // Valid stays up after acceptance until the next transaction or an idle wait replaces it.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    project_item(it);
  endtask

  // Drop valid, wait for every pending read, then let in-flight accumulates finish.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MODE:  map_mode    = data[2:0];
      REG_DIR_X: los_x       = data[15:0];
      REG_DIR_Y: los_y       = data[15:0];
      REG_DIR_Z: los_z       = data[15:0];
      REG_SCALE: value_scale = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic in_item_t random_item(bit cmd, logic [15:0] pix);
    in_item_t it;
    it.command = cmd;
    it.pixel_index = pix;
    it.path_length = $urandom;
    it.cell_size = $urandom;
    it.gas_density = $urandom;
    it.dust_amount = $urandom;
    it.gas_temperature = $urandom;
    it.vel_x = $urandom;
    it.vel_y = $urandom;
    it.vel_z = $urandom;
    // Keep most quantities moderate so sums stay away from saturation.
    if ($urandom_range(0, 3) != 0) begin
      it.path_length = $urandom_range(0, 32'h0004_0000);
      it.cell_size = $urandom_range(0, 32'h0003_0000);
      it.gas_density = $urandom_range(0, 32'h0010_0000);
      it.dust_amount = $urandom_range(0, 32'h0010_0000);
      it.gas_temperature = $urandom_range(0, 32'h0100_0000);
    end
    return it;
  endfunction

  // Pick a pixel from a small spread-out set, with the top index mixed in.
  function automatic logic [15:0] pick_pixel();
    int unsigned k;
    logic [15:0] p;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'(MAP_CELLS - 1 + 0);
    if (k == 1) return 16'hFFFF;
    p = 16'($urandom_range(0, 15));
    p = {p[3:0], 12'h0} | p;
    return p;
  endfunction

  task automatic test_extremes();
    in_item_t it;
    write_reg(REG_MODE, 32'(MODE_COLUMN));
    it = random_item(CMD_READ, 16'd0);
    send_item(it);
    it = '1; it.command = CMD_ACCUM; it.pixel_index = 16'd0;
    send_item(it);
    it = '0; it.command = CMD_ACCUM; it.pixel_index = 16'hFFFF;
    send_item(it);
    it.command = CMD_READ;
    send_item(it);
    it = '0; it.command = CMD_READ; it.pixel_index = 16'd0;
    send_item(it);
    it = '0; it.pixel_index = 16'd1; it.path_length = 32'h0001_0000;
    send_item(it);
    it.command = CMD_READ;
    send_item(it);
    it = '0; it.pixel_index = 16'd2; it.command = CMD_READ;
    send_item(it);
    wait_idle();
  endtask

  task automatic test_each_mode();
    in_item_t it;
    logic [2:0] m;
    for (int i = 0; i < 8; i++) begin
      m = 3'(i);
      write_reg(REG_MODE, 32'(m));
      it = random_item(CMD_ACCUM, 16'(16 + i));
      it.cell_size = 32'h0002_0000;
      it.vel_x = (i % 2) ? -32'sh0003_0000 : 32'sh0003_0000;
      send_item(it);
      if (i >= 5) it = random_item(CMD_ACCUM, 16'(16 + i - 5));
      it.pixel_index = 16'(16 + i);
      it.command = CMD_READ;
      // Unused modes write nothing: read a pixel that some mode did write.
      if (i >= 5) it.pixel_index = 16'd16;
      send_item(it);
      wait_idle();
    end
  endtask

  task automatic test_saturation();
    in_item_t it;
    write_reg(REG_MODE, 32'(MODE_GAS));
    write_reg(REG_SCALE, 32'hFFFF_FFFF);
    it = '1; it.command = CMD_ACCUM; it.pixel_index = 16'd40;
    send_item(it);
    send_item(it);
    it.command = CMD_READ;
    send_item(it);
    wait_idle();
    write_reg(REG_MODE, 32'(MODE_VEL));
    write_reg(REG_DIR_X, 32'(-16384));
    write_reg(REG_DIR_Y, 32'h0000_4000);
    write_reg(REG_DIR_Z, 32'(-16384));
    it = '1; it.command = CMD_ACCUM; it.pixel_index = 16'd41;
    it.vel_x = 32'sh7FFF_FFFF; it.vel_y = -32'sh8000_0000; it.vel_z = 32'sh7FFF_FFFF;
    send_item(it);
    send_item(it);
    it.command = CMD_READ;
    send_item(it);
    wait_idle();
    write_reg(REG_SCALE, 32'd0);
    send_item(it);
    wait_idle();
  endtask

  // Random phases, each under a fresh register setting.
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    in_item_t    it;
    logic [15:0] p;
    bit          rd;
    int unsigned tries;
    for (int ph = 0; ph < phases; ph++) begin
      write_reg(REG_MODE, $urandom_range(0, 4) + ($urandom_range(0, 9) == 0 ? 3 : 0));
      write_reg(REG_DIR_X, 32'($signed($urandom_range(0, 32768)) - 16384));
      write_reg(REG_DIR_Y, 32'($signed($urandom_range(0, 32768)) - 16384));
      write_reg(REG_DIR_Z, 32'($signed($urandom_range(0, 32768)) - 16384));
      write_reg(REG_SCALE, ($urandom_range(0, 3) == 0) ? $urandom
                                                      : $urandom_range(0, 32'h0004_0000));
      if (ph == phases - 1) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      for (int n = 0; n < per_phase; n++) begin
        rd = $urandom_range(0, 2) == 0;
        p = pick_pixel();
        tries = 0;
        while (rd && p < MAP_CELLS && !pixel_written.exists(p) && tries < 20) begin
          p = pick_pixel();
          tries++;
        end
        if (rd && p < MAP_CELLS && !pixel_written.exists(p)) p = 16'hFFFF;
        it = random_item(rd, p);
        send_item(it);
      end
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    map_mode = MODE_COLUMN;
    los_x = 16'sd16384;
    los_y = 16'sd0;
    los_z = 16'sd0;
    value_scale = 32'd65536;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold off until the store clear after reset finishes.
    while (!in_ready) @(posedge clk);
    test_extremes();
    test_each_mode();
    test_saturation();
    write_reg(REG_SCALE, 32'd65536);
    test_random(11, 45);
    wait_idle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
